>>> rtl/core/ptwm_pkg.sv
// ----------------------------------------------------------------------------
// ptwm_pkg: shared constants for the periodic tile wall mapper
// Field widths, register indexes and side codes.
// ----------------------------------------------------------------------------
package ptwm_pkg;

  localparam int SpanBits   = 10;
  localparam int GridBits   = 11;
  localparam int PeriodBits = 12;
  localparam int CodeBits   = 4;
  localparam int AddrBits   = 5;

  localparam logic [AddrBits-1:0] REG_SPAN     = 5'd0;
  localparam logic [AddrBits-1:0] REG_DETACHED = 5'd4;
  localparam logic [AddrBits-1:0] REG_GRID     = 5'd8;
  localparam logic [AddrBits-1:0] REG_SHIFT_X  = 5'd12;
  localparam logic [AddrBits-1:0] REG_SHIFT_Z  = 5'd16;

  localparam logic [CodeBits-1:0] SIDE_NONE = 4'd0;
  localparam logic [CodeBits-1:0] SIDE_NW   = 4'd1;
  localparam logic [CodeBits-1:0] SIDE_NE   = 4'd2;
  localparam logic [CodeBits-1:0] SIDE_SW   = 4'd3;
  localparam logic [CodeBits-1:0] SIDE_SE   = 4'd4;
  localparam logic [CodeBits-1:0] SIDE_W    = 4'd5;
  localparam logic [CodeBits-1:0] SIDE_E    = 4'd6;
  localparam logic [CodeBits-1:0] SIDE_N    = 4'd7;
  localparam logic [CodeBits-1:0] SIDE_S    = 4'd8;

endpackage

>>> rtl/core/ptwm_div_cell.sv
// ----------------------------------------------------------------------------
// ptwm_div_cell: one restoring division step for both axes
// Shifts one dividend bit into each partial remainder and subtracts the
// period when it fits, then hands the beat to the next cell.
// ----------------------------------------------------------------------------
module ptwm_div_cell #(
  parameter int MagBits = 17,
  parameter int Step    = 0
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  logic [ptwm_pkg::PeriodBits-1:0]        period_i,
  input  logic [MagBits-1:0]                     mag_x_i,
  input  logic [MagBits-1:0]                     mag_z_i,
  input  logic [ptwm_pkg::PeriodBits-1:0]        rem_x_i,
  input  logic [ptwm_pkg::PeriodBits-1:0]        rem_z_i,
  input  logic [MagBits-1:0]                     quo_x_i,
  input  logic [MagBits-1:0]                     quo_z_i,
  input  logic [3:0]                             side_i,
  input  logic [2*MagBits-1:0]                   shift_i,
  output logic                                   valid_o,
  output logic [ptwm_pkg::PeriodBits-1:0]        period_o,
  output logic [MagBits-1:0]                     mag_x_o,
  output logic [MagBits-1:0]                     mag_z_o,
  output logic [ptwm_pkg::PeriodBits-1:0]        rem_x_o,
  output logic [ptwm_pkg::PeriodBits-1:0]        rem_z_o,
  output logic [MagBits-1:0]                     quo_x_o,
  output logic [MagBits-1:0]                     quo_z_o,
  output logic [3:0]                             side_o,
  output logic [2*MagBits-1:0]                   shift_o
);

  localparam int Pb  = ptwm_pkg::PeriodBits;
  localparam int Bit = MagBits - 1 - Step;

  logic [Pb:0]   tx, tz;
  logic          fx, fz;
  logic          valid_q;
  logic [Pb-1:0] period_q, rem_x_q, rem_z_q;
  logic [MagBits-1:0] mag_x_q, mag_z_q, quo_x_q, quo_z_q;
  logic [3:0]    side_q;
  logic [2*MagBits-1:0] shift_q;

  assign tx = {rem_x_i, mag_x_i[Bit]};
  assign tz = {rem_z_i, mag_z_i[Bit]};
  assign fx = tx >= {1'b0, period_i};
  assign fz = tz >= {1'b0, period_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      period_q <= period_i;
      mag_x_q  <= mag_x_i;
      mag_z_q  <= mag_z_i;
      rem_x_q  <= fx ? Pb'(tx - {1'b0, period_i}) : tx[Pb-1:0];
      rem_z_q  <= fz ? Pb'(tz - {1'b0, period_i}) : tz[Pb-1:0];
      quo_x_q  <= {quo_x_i[MagBits-2:0], fx};
      quo_z_q  <= {quo_z_i[MagBits-2:0], fz};
      side_q   <= side_i;
      shift_q  <= shift_i;
    end
  end

  assign valid_o  = valid_q;
  assign period_o = period_q;
  assign mag_x_o  = mag_x_q;
  assign mag_z_o  = mag_z_q;
  assign rem_x_o  = rem_x_q;
  assign rem_z_o  = rem_z_q;
  assign quo_x_o  = quo_x_q;
  assign quo_z_o  = quo_z_q;
  assign side_o   = side_q;
  assign shift_o  = shift_q;

endmodule

>>> rtl/core/periodic_tile_wall_mapper.sv
// ----------------------------------------------------------------------------
// periodic_tile_wall_mapper: signed cells onto a periodic grid of walled tiles
// A chain of restoring division cells finds floor quotient and remainder.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake          Payload
// s_axis   in   tvalid/tready      tdata: coord_x, coord_z
// m_axis   out  tvalid/tready      tdata: tiles, origins; tuser: flags, code
// apb      in   psel/penable       five registers at 4*i
// One beat is accepted every cycle unless the output stalls; an accepted beat
// passes through one entry stage, COORD_BITS+1 division cells and one output
// stage. The whole chain advances only when the output register is free or
// being taken, so stalls hold every cell.
// Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module periodic_tile_wall_mapper #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,  // coord_x, coord_z
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tile_x, tile_z, origin_x, origin_z
  output logic [((4*COORD_BITS+4+7)/8)*8-1:0] m_axis_tdata,
  // wall, west, east, north, south, side_code
  output logic [8:0]                    m_axis_tuser,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptwm_pkg::AddrBits-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int Cb   = COORD_BITS;
  localparam int Mb   = COORD_BITS + 1;
  localparam int Pb   = ptwm_pkg::PeriodBits;
  localparam int Ob   = COORD_BITS + 1;
  localparam int Nc   = Mb;
  localparam int OutW = ((4*Ob+7)/8)*8;

  logic [ptwm_pkg::SpanBits-1:0] span_q;
  logic                          det_q;
  logic [ptwm_pkg::GridBits-1:0] grid_q;
  logic [Cb-1:0]                 shx_q, shz_q;
  logic                          wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q <= 10'd16;
      det_q  <= 1'b0;
      grid_q <= 11'd18;
      shx_q  <= '0;
      shz_q  <= '0;
    end else if (wr) begin
      case (paddr)
        ptwm_pkg::REG_SPAN:     span_q <= pwdata[ptwm_pkg::SpanBits-1:0];
        ptwm_pkg::REG_DETACHED: det_q  <= pwdata[0];
        ptwm_pkg::REG_GRID:     grid_q <= pwdata[ptwm_pkg::GridBits-1:0];
        ptwm_pkg::REG_SHIFT_X:  shx_q  <= pwdata[Cb-1:0];
        ptwm_pkg::REG_SHIFT_Z:  shz_q  <= pwdata[Cb-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ptwm_pkg::REG_SPAN:     prdata = 32'(span_q);
      ptwm_pkg::REG_DETACHED: prdata = 32'(det_q);
      ptwm_pkg::REG_GRID:     prdata = 32'(grid_q);
      ptwm_pkg::REG_SHIFT_X:  prdata = 32'(shx_q);
      ptwm_pkg::REG_SHIFT_Z:  prdata = 32'(shz_q);
      default:                prdata = '0;
    endcase
  end

  // Period from the registers; the user keeps it stable while items flow (not enforced here).
  logic [Pb-1:0] span_p2, grid_e, period;
  assign span_p2 = Pb'(span_q) + Pb'(2);
  assign grid_e  = Pb'(grid_q);
  always_comb begin
    if (!det_q) begin
      period = Pb'(span_q) + Pb'(1);
    end else if (grid_e <= Pb'(2) || grid_e < span_p2) begin
      period = span_p2 - Pb'(1);
    end else begin
      period = grid_e - Pb'(1);
    end
  end

  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // Entry stage: offsets, sign split into magnitude for the chain.
  logic          e_v_q;
  logic [Mb-1:0] e_mx_q, e_mz_q;
  logic [1:0]    e_neg_q;
  logic [Mb-1:0] ox, oz;
  assign ox = Mb'($signed(s_axis_tdata[Cb-1:0])) - Mb'($signed(shx_q));
  assign oz = Mb'($signed(s_axis_tdata[2*Cb-1:Cb])) - Mb'($signed(shz_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
    end else if (adv) begin
      e_v_q <= s_axis_tvalid;
    end
  end

  // Negative o: floor(o/P) = -(((-o)-1)/P) - 1, remainder P-1-r.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_neg_q <= {oz[Mb-1], ox[Mb-1]};
      e_mx_q  <= ox[Mb-1] ? ~ox : ox;
      e_mz_q  <= oz[Mb-1] ? ~oz : oz;
    end
  end

  logic          c_v   [Nc+1];
  logic [Pb-1:0] c_p   [Nc+1];
  logic [Mb-1:0] c_mx  [Nc+1];
  logic [Mb-1:0] c_mz  [Nc+1];
  logic [Pb-1:0] c_rx  [Nc+1];
  logic [Pb-1:0] c_rz  [Nc+1];
  logic [Mb-1:0] c_qx  [Nc+1];
  logic [Mb-1:0] c_qz  [Nc+1];
  logic [3:0]    c_sd  [Nc+1];
  logic [2*Mb-1:0] c_sh [Nc+1];

  assign c_v[0]  = e_v_q;
  assign c_p[0]  = period;
  assign c_mx[0] = e_mx_q;
  assign c_mz[0] = e_mz_q;
  assign c_rx[0] = '0;
  assign c_rz[0] = '0;
  assign c_qx[0] = '0;
  assign c_qz[0] = '0;
  assign c_sd[0] = {2'b00, e_neg_q};
  assign c_sh[0] = {Mb'($signed(shz_q)), Mb'($signed(shx_q))};

  for (genvar g = 0; g < Nc; g++) begin : g_cell
    ptwm_div_cell #(.MagBits(Mb), .Step(g)) u_cell (
      .clk_i, .rst_ni, .en_i(adv),
      .valid_i(c_v[g]), .period_i(c_p[g]), .mag_x_i(c_mx[g]), .mag_z_i(c_mz[g]),
      .rem_x_i(c_rx[g]), .rem_z_i(c_rz[g]), .quo_x_i(c_qx[g]), .quo_z_i(c_qz[g]),
      .side_i(c_sd[g]), .shift_i(c_sh[g]),
      .valid_o(c_v[g+1]), .period_o(c_p[g+1]), .mag_x_o(c_mx[g+1]),
      .mag_z_o(c_mz[g+1]), .rem_x_o(c_rx[g+1]), .rem_z_o(c_rz[g+1]),
      .quo_x_o(c_qx[g+1]), .quo_z_o(c_qz[g+1]), .side_o(c_sd[g+1]),
      .shift_o(c_sh[g+1])
    );
  end

  // Final correction: sign, remainder, origin product, flags.
  logic [Pb-1:0] p, rx, rz;
  logic [Mb-1:0] tx, tz, gx, gz;
  logic [Mb+Pb-1:0] px, pz;
  logic w, e, n, s;
  logic [3:0] code;
  assign p  = c_p[Nc];
  assign tx = c_sd[Nc][0] ? ~c_qx[Nc] : c_qx[Nc];
  assign tz = c_sd[Nc][1] ? ~c_qz[Nc] : c_qz[Nc];
  assign rx = c_sd[Nc][0] ? p - Pb'(1) - c_rx[Nc] : c_rx[Nc];
  assign rz = c_sd[Nc][1] ? p - Pb'(1) - c_rz[Nc] : c_rz[Nc];
  assign px = $signed(tx) * $signed({1'b0, p});
  assign pz = $signed(tz) * $signed({1'b0, p});
  assign gx = px[Mb-1:0] + c_sh[Nc][Mb-1:0];
  assign gz = pz[Mb-1:0] + c_sh[Nc][2*Mb-1:Mb];
  assign w = rx == '0;
  assign n = rz == '0;
  assign e = (p == Pb'(1)) || (rx == Pb'(1));
  assign s = (p == Pb'(1)) || (rz == Pb'(1));

  always_comb begin
    if (w && n)      code = ptwm_pkg::SIDE_NW;
    else if (e && n) code = ptwm_pkg::SIDE_NE;
    else if (w && s) code = ptwm_pkg::SIDE_SW;
    else if (e && s) code = ptwm_pkg::SIDE_SE;
    else if (w)      code = ptwm_pkg::SIDE_W;
    else if (e)      code = ptwm_pkg::SIDE_E;
    else if (n)      code = ptwm_pkg::SIDE_N;
    else if (s)      code = ptwm_pkg::SIDE_S;
    else             code = ptwm_pkg::SIDE_NONE;
  end

  logic o_v_q;
  logic [OutW-1:0] o_d_q;
  logic [8:0] o_u_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (adv) begin
      o_v_q <= c_v[Nc];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_d_q <= OutW'({gz, gx, tz, tx});
      o_u_q <= {code, s, n, e, w, w || n};
    end
  end

  assign m_axis_tvalid = o_v_q;
  assign m_axis_tdata  = o_d_q;
  assign m_axis_tuser  = o_u_q;

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stage");
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tuser[1] || m_axis_tuser[3])))
    else $error("wall flag disagrees with side flags");
`endif

endmodule
